>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of clk, off during reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/cpf_pkg.sv
// Types, constants and helper functions of the cutoff pair finder.
package cpf_pkg;

  localparam int COORD_BITS     = 16;
  localparam int MAX_POINTS_DEF = 64;
  localparam int INDEX_BITS     = 6;
  localparam int CUTOFF_BITS    = 16;
  localparam int DIFF_W         = 17;
  localparam int SQ_W           = 2 * DIFF_W;
  localparam int D2_W           = SQ_W + 2;
  localparam int LIM_W          = 2 * CUTOFF_BITS;
  localparam int APB_DATA_W     = 32;
  localparam int PADDR_W        = 3;
  localparam int SAT_W          = (COORD_BITS + 1 > DIFF_W) ? COORD_BITS + 1 : DIFF_W;
  localparam logic [DIFF_W-1:0] DIFF_SAT = DIFF_W'(65536);

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_END   = 1'b1;
  localparam logic KIND_PAIR = 1'b0;
  localparam logic KIND_END  = 1'b1;
  localparam logic REG_CUTOFF = 1'b0;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic   cmd;
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
  } in_word_t;

  typedef struct packed {
    logic                  kind;
    logic [INDEX_BITS-1:0] first_index;
    logic [INDEX_BITS-1:0] second_index;
    coord_t                first_x;
    coord_t                first_y;
    coord_t                first_z;
    coord_t                second_x;
    coord_t                second_y;
    coord_t                second_z;
    logic                  overflow;
    logic                  last_of_run;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FLUSH,
    ST_MARK
  } ctrl_state_t;

  typedef struct packed {
    logic wr_en;
    logic issue;
    logic flush;
    logic mark;
    logic mark_ovf;
  } ctrl_cmd_t;

  typedef struct packed {
    logic adv;
    logic pipe_empty;
    logic p_valid;
    logic o_free;
  } dp_status_t;

  function automatic logic [DIFF_W-1:0] sat_abs_diff(coord_t a, coord_t b);
    logic signed [COORD_BITS:0] d;
    logic [COORD_BITS:0]        m;
    logic [SAT_W-1:0]           mw;
    d  = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    m  = d[COORD_BITS] ? (COORD_BITS+1)'(-d) : (COORD_BITS+1)'(d);
    mw = SAT_W'(m);
    if (mw > SAT_W'(DIFF_SAT)) begin
      return DIFF_SAT;
    end
    return DIFF_W'(mw);
  endfunction

endpackage

>>> hdl/cutoff_pair_finder.sv
// Top level of the cutoff pair finder: configuration register, controller and datapath.
//
//   Channel   Direction  Handshake          Word
//   in_       input      in_valid/in_stall  in_word_t: cmd, pos_x, pos_y, pos_z
//   out_      output     out_valid/out_stall out_word_t: one pair or set-end marker
//   config    input      APB write/read     cutoff at byte address 0
//
// An add word with k stored points is checked against all k: one stored point is read
// from the store each cycle unless the pipeline is frozen, and runs through the read,
// difference and square registers. An end on a non-empty set goes through the marker
// state; a dropped point, a set's first point or an end on an empty set stays in idle.
// Reset is synchronous and active low; the point store is not cleared by it.
// A stalled output with a pair pending freezes the distance pipeline on a new hit.
module cutoff_pair_finder #(
  parameter int MAX_POINTS = cpf_pkg::MAX_POINTS_DEF,
  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  cpf_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output cpf_pkg::out_word_t                  out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cpf_pkg::PADDR_W-1:0]         paddr,
  input  logic [cpf_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [cpf_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);

  logic [cpf_pkg::CUTOFF_BITS-1:0] cutoff_r;
  logic                            reg_sel;
  cpf_pkg::ctrl_cmd_t              cmd;
  cpf_pkg::dp_status_t             sts;
  logic [IDX_W-1:0]                wr_addr, rd_addr;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[cpf_pkg::PADDR_W-1] == cpf_pkg::REG_CUTOFF);
  assign prdata  = reg_sel ? cpf_pkg::APB_DATA_W'(cutoff_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      cutoff_r <= pwdata[cpf_pkg::CUTOFF_BITS-1:0];
    end
  end

  cpf_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_stall (in_stall),
    .cmd      (cmd),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .sts      (sts)
  );

  cpf_datapath #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cutoff    (cutoff_r),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> hdl/cpf_ctrl.sv
// Controller state machine: accepts words, sequences the scan, flush and set-end marker.
module cpf_ctrl #(
  parameter int MAX_POINTS = cpf_pkg::MAX_POINTS_DEF,
  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_cmd,
  output logic                 in_stall,
  output cpf_pkg::ctrl_cmd_t   cmd,
  output logic [IDX_W-1:0]     wr_addr,
  output logic [IDX_W-1:0]     rd_addr,
  input  cpf_pkg::dp_status_t  sts
);

  cpf_pkg::ctrl_state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic             dropped_r, dropped_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cpf_pkg::ST_IDLE;
      count_r    <= '0;
      k_r        <= '0;
      scan_idx_r <= '0;
      dropped_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      k_r        <= k_nxt;
      scan_idx_r <= scan_idx_nxt;
      dropped_r  <= dropped_nxt;
    end
  end

  assign wr_addr = count_r[IDX_W-1:0];
  assign rd_addr = scan_idx_r;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    k_nxt        = k_r;
    scan_idx_nxt = scan_idx_r;
    dropped_nxt  = dropped_r;
    in_stall     = 1'b1;
    cmd          = '0;
    cmd.mark_ovf = dropped_r;
    unique case (state_r)
      cpf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_cmd == cpf_pkg::CMD_END) begin
            if (count_r != '0) begin
              state_nxt = cpf_pkg::ST_MARK;
            end
          end else if (count_r >= CNT_W'(MAX_POINTS)) begin
            dropped_nxt = 1'b1;
          end else begin
            cmd.wr_en    = 1'b1;
            count_nxt    = count_r + CNT_W'(1);
            k_nxt        = count_r;
            scan_idx_nxt = '0;
            if (count_r != '0) begin
              state_nxt = cpf_pkg::ST_SCAN;
            end
          end
        end
      end
      cpf_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.adv) begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
          if (CNT_W'(scan_idx_r) == k_r - CNT_W'(1)) begin
            state_nxt = cpf_pkg::ST_DRAIN;
          end
        end
      end
      cpf_pkg::ST_DRAIN: begin
        if (sts.pipe_empty) begin
          state_nxt = cpf_pkg::ST_FLUSH;
        end
      end
      cpf_pkg::ST_FLUSH: begin
        cmd.flush = 1'b1;
        if (!sts.p_valid || sts.o_free) begin
          state_nxt = cpf_pkg::ST_IDLE;
        end
      end
      cpf_pkg::ST_MARK: begin
        cmd.mark = 1'b1;
        if (sts.o_free) begin
          count_nxt   = '0;
          dropped_nxt = 1'b0;
          state_nxt   = cpf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cpf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/cpf_datapath.sv
// Datapath: point store, distance pipeline, pending pair and output register.
module cpf_datapath #(
  parameter int MAX_POINTS = cpf_pkg::MAX_POINTS_DEF,
  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cpf_pkg::in_word_t                   in_data,
  input  logic [cpf_pkg::CUTOFF_BITS-1:0]     cutoff,
  input  cpf_pkg::ctrl_cmd_t                  cmd,
  input  logic [IDX_W-1:0]                    wr_addr,
  input  logic [IDX_W-1:0]                    rd_addr,
  output cpf_pkg::dp_status_t                 sts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output cpf_pkg::out_word_t                  out_data
);

  cpf_pkg::point_t store_r [0:MAX_POINTS-1];

  cpf_pkg::point_t new_pt_r;
  logic [IDX_W-1:0] sec_idx_r;
  logic [cpf_pkg::LIM_W-1:0] lim_r;

  logic             v1_r, v2_r, v3_r;
  logic [IDX_W-1:0] idx1_r, idx2_r, idx3_r;
  cpf_pkg::point_t  rd_r, pt2_r, pt3_r;
  logic [cpf_pkg::DIFF_W-1:0] dx2_r, dy2_r, dz2_r;
  logic [cpf_pkg::SQ_W-1:0]   sx3_r, sy3_r, sz3_r;

  logic             p_valid_r, p_valid_nxt;
  logic [IDX_W-1:0] p_idx_r;
  cpf_pkg::point_t  p_pt_r;

  logic               o_valid_r, o_valid_nxt;
  cpf_pkg::out_word_t out_r;

  logic                     adv, hit, o_free, o_load, flush_go, mark_go;
  logic [cpf_pkg::D2_W-1:0] d2;
  cpf_pkg::out_word_t       pair_w, mark_w;

  assign d2 = cpf_pkg::D2_W'(sx3_r) + cpf_pkg::D2_W'(sy3_r) + cpf_pkg::D2_W'(sz3_r);
  assign hit      = v3_r && (d2 < cpf_pkg::D2_W'(lim_r));
  assign o_free   = !o_valid_r || !out_stall;
  assign adv      = !(hit && p_valid_r && !o_free);
  assign flush_go = cmd.flush && p_valid_r && o_free;
  assign mark_go  = cmd.mark && o_free;
  assign o_load   = (adv && hit && p_valid_r) || flush_go || mark_go;

  assign sts.adv        = adv;
  assign sts.pipe_empty = !v1_r && !v2_r && !v3_r;
  assign sts.p_valid    = p_valid_r;
  assign sts.o_free     = o_free;

  always_comb begin
    pair_w              = '0;
    pair_w.kind         = cpf_pkg::KIND_PAIR;
    pair_w.first_index  = cpf_pkg::INDEX_BITS'(p_idx_r);
    pair_w.second_index = cpf_pkg::INDEX_BITS'(sec_idx_r);
    pair_w.first_x      = p_pt_r.x;
    pair_w.first_y      = p_pt_r.y;
    pair_w.first_z      = p_pt_r.z;
    pair_w.second_x     = new_pt_r.x;
    pair_w.second_y     = new_pt_r.y;
    pair_w.second_z     = new_pt_r.z;
    pair_w.last_of_run  = flush_go;
    mark_w              = '0;
    mark_w.kind         = cpf_pkg::KIND_END;
    mark_w.overflow     = cmd.mark_ovf;
    mark_w.last_of_run  = 1'b1;
  end

  always_comb begin
    p_valid_nxt = p_valid_r;
    if (adv && hit) begin
      p_valid_nxt = 1'b1;
    end else if (flush_go) begin
      p_valid_nxt = 1'b0;
    end
    o_valid_nxt = o_load ? 1'b1 : (o_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      store_r[wr_addr] <= cpf_pkg::point_t'({in_data.pos_x, in_data.pos_y, in_data.pos_z});
    end
    if (adv) begin
      rd_r <= store_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    lim_r <= cpf_pkg::LIM_W'(cutoff) * cpf_pkg::LIM_W'(cutoff);
    if (cmd.wr_en) begin
      new_pt_r  <= cpf_pkg::point_t'({in_data.pos_x, in_data.pos_y, in_data.pos_z});
      sec_idx_r <= wr_addr;
    end
    if (adv) begin
      idx1_r <= rd_addr;
      idx2_r <= idx1_r;
      pt2_r  <= rd_r;
      dx2_r  <= cpf_pkg::sat_abs_diff(new_pt_r.x, rd_r.x);
      dy2_r  <= cpf_pkg::sat_abs_diff(new_pt_r.y, rd_r.y);
      dz2_r  <= cpf_pkg::sat_abs_diff(new_pt_r.z, rd_r.z);
      idx3_r <= idx2_r;
      pt3_r  <= pt2_r;
      sx3_r  <= dx2_r * dx2_r;
      sy3_r  <= dy2_r * dy2_r;
      sz3_r  <= dz2_r * dz2_r;
      if (hit) begin
        p_idx_r <= idx3_r;
        p_pt_r  <= pt3_r;
      end
    end
    if (o_load) begin
      out_r <= mark_go ? mark_w : pair_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      p_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        v1_r <= cmd.issue;
        v2_r <= v1_r;
        v3_r <= v2_r;
      end
      p_valid_r <= p_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  assign out_valid = o_valid_r;
  assign out_data  = out_r;

endmodule

>>> hdl/cpf_checker.sv
// Port-level checker of the cutoff pair finder and its bind to the top level.
`include "assert_macros.svh"

module cpf_checker #(
  parameter int MAX_POINTS = cpf_pkg::MAX_POINTS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input cpf_pkg::out_word_t out_data
);

  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "Stalled output word changed.")
  `ASSERT_IMPLIES(a_mark_form, out_valid && out_data.kind == cpf_pkg::KIND_END, out_data.last_of_run && out_data.first_index == '0 && out_data.second_index == '0, "Malformed set-end word.")
  `ASSERT_IMPLIES(a_pair_ovf, out_valid && out_data.kind == cpf_pkg::KIND_PAIR, !out_data.overflow, "Pair word carries overflow.")
  `ASSERT_IMPLIES(a_pair_order, out_valid && out_data.kind == cpf_pkg::KIND_PAIR, (MAX_POINTS > 64) || (out_data.first_index < out_data.second_index), "Pair indices out of order.")

endmodule

bind cutoff_pair_finder cpf_checker #(
  .MAX_POINTS(MAX_POINTS)
) u_cpf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> test/pair_book_pkg.sv
// Scoreboard class that predicts and checks the result words of the cutoff pair finder.
package pair_book_pkg;
  import cpf_pkg::*;

  localparam int POINT_SLOTS = MAX_POINTS_DEF;
  localparam longint DIFF_CAP = 65536;

  class neighbor_pair_book;
    point_t stored[POINT_SLOTS];
    int n_stored;
    bit dropped;
    logic [CUTOFF_BITS-1:0] cutoff;
    out_word_t expected[$];
    int errors;
    int words_in;
    int pairs_seen;
    int ends_seen;

    function new();
      n_stored = 0;
      dropped = 1'b0;
      cutoff = '0;
      errors = 0;
      words_in = 0;
      pairs_seen = 0;
      ends_seen = 0;
    endfunction

    function void set_cutoff(logic [CUTOFF_BITS-1:0] value);
      cutoff = value;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function longint unsigned sq_gap(coord_t a, coord_t b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) begin
        d = -d;
      end
      if (d > DIFF_CAP) begin
        d = DIFF_CAP;
      end
      return longint'(d * d);
    endfunction

    // An add word that finds room records the point and queues every close pair it forms; an end
    // word on a non-empty set queues one marker word and empties the store.
    function void accept_word(in_word_t w);
      out_word_t held;
      bit have_held;
      point_t p;
      longint unsigned lim;
      longint unsigned d2;
      words_in++;
      if (w.cmd == CMD_END) begin
        if (n_stored == 0) begin
          return;
        end
        held = '0;
        held.kind = KIND_END;
        held.overflow = dropped;
        held.last_of_run = 1'b1;
        expected.push_back(held);
        n_stored = 0;
        dropped = 1'b0;
        return;
      end
      if (n_stored >= POINT_SLOTS) begin
        dropped = 1'b1;
        return;
      end
      p.x = w.pos_x;
      p.y = w.pos_y;
      p.z = w.pos_z;
      lim = longint'(cutoff) * longint'(cutoff);
      have_held = 1'b0;
      held = '0;
      for (int i = 0; i < n_stored; i++) begin
        d2 = sq_gap(p.x, stored[i].x) + sq_gap(p.y, stored[i].y) + sq_gap(p.z, stored[i].z);
        if (d2 < lim) begin
          if (have_held) begin
            expected.push_back(held);
          end
          held = '0;
          held.kind = KIND_PAIR;
          held.first_index = INDEX_BITS'(i);
          held.second_index = INDEX_BITS'(n_stored);
          held.first_x = stored[i].x;
          held.first_y = stored[i].y;
          held.first_z = stored[i].z;
          held.second_x = p.x;
          held.second_y = p.y;
          held.second_z = p.z;
          have_held = 1'b1;
        end
      end
      if (have_held) begin
        held.last_of_run = 1'b1;
        expected.push_back(held);
      end
      stored[n_stored] = p;
      n_stored++;
    endfunction

    function void compare_field(time stamp, string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0d ns: %s expected %h actual %h", stamp, field, want, got);
      end
    endfunction

    function void check_word(out_word_t got, time stamp);
      out_word_t want;
      if (expected.size() == 0) begin
        errors++;
        $display("%0d ns: result word expected none actual %h", stamp, got);
        return;
      end
      want = expected.pop_front();
      if (want.kind == KIND_END) begin
        ends_seen++;
      end else begin
        pairs_seen++;
      end
      compare_field(stamp, "kind", want.kind, got.kind);
      compare_field(stamp, "first_index", want.first_index, got.first_index);
      compare_field(stamp, "second_index", want.second_index, got.second_index);
      compare_field(stamp, "first_x", want.first_x, got.first_x);
      compare_field(stamp, "first_y", want.first_y, got.first_y);
      compare_field(stamp, "first_z", want.first_z, got.first_z);
      compare_field(stamp, "second_x", want.second_x, got.second_x);
      compare_field(stamp, "second_y", want.second_y, got.second_y);
      compare_field(stamp, "second_z", want.second_z, got.second_z);
      compare_field(stamp, "overflow", want.overflow, got.overflow);
      compare_field(stamp, "last_of_run", want.last_of_run, got.last_of_run);
    endfunction
  endclass

endpackage

>>> test/tb_top.sv
// Testbench top: drives point sets and cutoff settings into the pair finder and checks its words.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cpf_pkg::*;
  import pair_book_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_TAIL = 100;
  localparam int RANDOM_WORDS = 230;
  localparam int LONG_HOLD = 400;
  localparam logic [PADDR_W-1:0] CUTOFF_ADDR = PADDR_W'(4 * REG_CUTOFF);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  neighbor_pair_book book;
  int cycles = 0;
  int burst_left = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int words_sent = 0;
  int settings_used = 0;
  logic [CUTOFF_BITS-1:0] cutoff_now = '0;

  always #2 clk = ~clk;

  cutoff_pair_finder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_word),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      book.check_word(out_word, $time);
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 60);
      end
      mode_left = mode_left - 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  task automatic send_word(in_word_t w);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    book.accept_word(w);
    words_sent++;
  endtask

  task automatic send_point(int x, int y, int z);
    in_word_t w;
    w.cmd = CMD_ADD;
    w.pos_x = coord_t'(x);
    w.pos_y = coord_t'(y);
    w.pos_z = coord_t'(z);
    send_word(w);
  endtask

  task automatic send_end();
    in_word_t w;
    w.cmd = CMD_END;
    w.pos_x = coord_t'($urandom);
    w.pos_y = coord_t'($urandom);
    w.pos_z = coord_t'($urandom);
    send_word(w);
  endtask

  task automatic send_cluster(int count, int spread);
    int cx;
    int cy;
    int cz;
    cx = int'($urandom_range(0, 50000)) - 25000;
    cy = int'($urandom_range(0, 50000)) - 25000;
    cz = int'($urandom_range(0, 50000)) - 25000;
    repeat (count) begin
      send_point(cx + int'($urandom_range(0, 2 * spread)) - spread,
                 cy + int'($urandom_range(0, 2 * spread)) - spread,
                 cz + int'($urandom_range(0, 2 * spread)) - spread);
    end
  endtask

  task automatic send_mixed(int count);
    repeat (count) begin
      if ($urandom_range(0, 2) == 0) begin
        send_end();
      end else begin
        send_point(int'($urandom_range(0, 600)) - 300, int'($urandom_range(0, 600)) - 300,
                   int'($urandom_range(0, 600)) - 300);
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_cutoff(logic [CUTOFF_BITS-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CUTOFF_ADDR;
    pwdata <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    book.set_cutoff(value);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DATA_W'(value)) begin
      book.errors++;
      $display("%0d ns: cutoff readback expected %h actual %h", $time, APB_DATA_W'(value), prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    cutoff_now = value;
    settings_used++;
  endtask

  initial begin
    int stop;
    int set_no;
    int pick;
    book = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With a zero cutoff even coincident points do not pair; an end on an empty set is silent.
    write_cutoff('0);
    send_point(0, 0, 0);
    send_point(0, 0, 0);
    send_end();
    send_end();
    wait_idle();

    // Coordinate extremes against the widest cutoff.
    write_cutoff('1);
    send_point(-32768, -32768, -32768);
    send_point(32767, 32767, 32767);
    send_point(0, 0, 0);
    send_point(32767, -32768, 0);
    send_end();
    send_end();
    wait_idle();

    // A distance exactly at the cutoff does not pair; just inside it does.
    write_cutoff(CUTOFF_BITS'(256));
    send_point(0, 0, 0);
    send_point(256, 0, 0);
    send_point(0, 255, 0);
    send_point(-100, -100, -100);
    send_end();

    stop = words_sent + RANDOM_WORDS;
    set_no = 0;
    while (words_sent < stop) begin
      if (set_no % 4 == 0) begin
        wait_idle();
        case (set_no / 4)
          0: write_cutoff('1);
          1: write_cutoff('0);
          default: begin
            if ($urandom_range(0, 4) == 0) begin
              write_cutoff(CUTOFF_BITS'($urandom));
            end else begin
              write_cutoff(CUTOFF_BITS'($urandom_range(64, 3000)));
            end
          end
        endcase
      end
      if (set_no == 2) begin
        hold_requests++;
        send_cluster(16, 2000);
        send_end();
      end else if (set_no == 9) begin
        send_cluster(POINT_SLOTS + 2, int'(cutoff_now) / 2 + 1);
        send_end();
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          send_cluster($urandom_range(2, 10), $urandom_range(4, 1500));
          send_end();
        end else if (pick < 9) begin
          repeat ($urandom_range(1, 5)) send_point($urandom, $urandom, $urandom);
          send_end();
        end else begin
          send_mixed($urandom_range(2, 6));
        end
      end
      set_no++;
    end
    wait_idle();

    $display("Run covered %0d input words over %0d cutoff settings, with a full store and a long output hold.",
             book.words_in, settings_used);
    $display("Checked %0d pair words and %0d set-end words.", book.pairs_seen, book.ends_seen);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/cpf_pkg.sv
hdl/cpf_ctrl.sv
hdl/cpf_datapath.sv
hdl/cutoff_pair_finder.sv
hdl/cpf_checker.sv
test/pair_book_pkg.sv
test/tb_top.sv
